@@ hw/rtl/ldbd_pkg.sv @@
// ladder button debouncer package: widths, register indexes and shared structs
// used by the config, decode, debounce and top-level modules; no dependencies
`default_nettype none

package ldbd_pkg;

   // fixed field widths
   localparam int unsigned SAMPLE_BITS     = 12;
   localparam int unsigned DELAY_BITS      = 16;
   localparam int unsigned TIME_BITS       = 32;
   localparam int unsigned LADDER_ONE_KEYS = 4;
   localparam int unsigned LADDER_TWO_KEYS = 2;
   localparam int unsigned KEY_COUNT       = LADDER_ONE_KEYS + LADDER_TWO_KEYS + 1;
   localparam int unsigned POWER_BIT       = LADDER_ONE_KEYS + LADDER_TWO_KEYS;

   // stream payload widths, padded to whole bytes
   localparam int unsigned REQ_FIELD_BITS  = 2 * SAMPLE_BITS + 1 + TIME_BITS;
   localparam int unsigned REQ_DATA_BITS   = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int unsigned RSP_FIELD_BITS  = 3 * KEY_COUNT + TIME_BITS;
   localparam int unsigned RSP_DATA_BITS   = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // control register port
   localparam int unsigned CSR_INDEX_BITS  = 3;
   localparam int unsigned CSR_DATA_BITS   = DELAY_BITS;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_NO_BUTTON_LEVEL   = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LADDER_ONE_EDGE_A = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LADDER_ONE_EDGE_B = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LADDER_ONE_EDGE_C = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LADDER_TWO_EDGE   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SETTLE_DELAY_MS   = 3'd5;

   // register reset values
   localparam logic [SAMPLE_BITS-1:0] NO_BUTTON_LEVEL_RESET   = 12'd3800;
   localparam logic [SAMPLE_BITS-1:0] LADDER_ONE_EDGE_A_RESET = 12'd3100;
   localparam logic [SAMPLE_BITS-1:0] LADDER_ONE_EDGE_B_RESET = 12'd2090;
   localparam logic [SAMPLE_BITS-1:0] LADDER_ONE_EDGE_C_RESET = 12'd750;
   localparam logic [SAMPLE_BITS-1:0] LADDER_TWO_EDGE_RESET   = 12'd1120;
   localparam logic [DELAY_BITS-1:0]  SETTLE_DELAY_MS_RESET   = 16'd5;

   typedef logic [KEY_COUNT-1:0] key_mask_type;

   // threshold and timing settings
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] no_button_level;
      logic [SAMPLE_BITS-1:0] ladder_one_edge_a;
      logic [SAMPLE_BITS-1:0] ladder_one_edge_b;
      logic [SAMPLE_BITS-1:0] ladder_one_edge_c;
      logic [SAMPLE_BITS-1:0] ladder_two_edge;
      logic [DELAY_BITS-1:0]  settle_delay_ms;
   } cfg_type;

   // one sample tick
   typedef struct packed {
      logic [TIME_BITS-1:0]   now_ms;
      logic                   power_pin_high;
      logic [SAMPLE_BITS-1:0] ladder_two_sample;
      logic [SAMPLE_BITS-1:0] ladder_one_sample;
   } sample_type;

   // one result
   typedef struct packed {
      logic [TIME_BITS-1:0] held_ms;
      key_mask_type         released_keys;
      key_mask_type         pressed_keys;
      key_mask_type         stable_keys;
   } result_type;

endpackage

`default_nettype wire

@@ hw/rtl/ldbd_csr.sv @@
// ladder button debouncer settings registers
// depends on ldbd_pkg for indexes, reset values and cfg_type
`default_nettype none

module ldbd_csr
   import ldbd_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                        cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the write; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_NO_BUTTON_LEVEL:   cfg_in.no_button_level   = csr_wdata[SAMPLE_BITS-1:0];
            CSR_LADDER_ONE_EDGE_A: cfg_in.ladder_one_edge_a = csr_wdata[SAMPLE_BITS-1:0];
            CSR_LADDER_ONE_EDGE_B: cfg_in.ladder_one_edge_b = csr_wdata[SAMPLE_BITS-1:0];
            CSR_LADDER_ONE_EDGE_C: cfg_in.ladder_one_edge_c = csr_wdata[SAMPLE_BITS-1:0];
            CSR_LADDER_TWO_EDGE:   cfg_in.ladder_two_edge   = csr_wdata[SAMPLE_BITS-1:0];
            CSR_SETTLE_DELAY_MS:   cfg_in.settle_delay_ms   = csr_wdata[DELAY_BITS-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   // register bank
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.no_button_level   <= NO_BUTTON_LEVEL_RESET;
         cfg_ff.ladder_one_edge_a <= LADDER_ONE_EDGE_A_RESET;
         cfg_ff.ladder_one_edge_b <= LADDER_ONE_EDGE_B_RESET;
         cfg_ff.ladder_one_edge_c <= LADDER_ONE_EDGE_C_RESET;
         cfg_ff.ladder_two_edge   <= LADDER_TWO_EDGE_RESET;
         cfg_ff.settle_delay_ms   <= SETTLE_DELAY_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ hw/rtl/ldbd_key_decode.sv @@
// ladder button debouncer key decode: threshold windows on both ladders plus power pin
// depends on ldbd_pkg for cfg_type, sample_type and key_mask_type
`default_nettype none

module ldbd_key_decode
   import ldbd_pkg::*;
(
   input  wire cfg_type    cfg,
   input  wire sample_type sample,
   output key_mask_type    raw_keys
);

   logic [SAMPLE_BITS-1:0] s1;
   logic [SAMPLE_BITS-1:0] s2;
   logic [LADDER_ONE_KEYS-1:0] one_keys;
   logic [LADDER_TWO_KEYS-1:0] two_keys;

   assign s1 = sample.ladder_one_sample;
   assign s2 = sample.ladder_two_sample;

   // ladder one, first matching window wins
   always_comb begin
      one_keys = '0;
      priority if (s1 > cfg.ladder_one_edge_a && s1 <= cfg.no_button_level) begin
         one_keys[0] = 1'b1;
      end else if (s1 > cfg.ladder_one_edge_b && s1 <= cfg.ladder_one_edge_a) begin
         one_keys[1] = 1'b1;
      end else if (s1 > cfg.ladder_one_edge_c && s1 <= cfg.ladder_one_edge_b) begin
         one_keys[2] = 1'b1;
      end else if (s1 <= cfg.ladder_one_edge_c) begin
         one_keys[3] = 1'b1;
      end else begin
         one_keys = '0;
      end
   end

   // ladder two, bottom key has no lower bound
   always_comb begin
      two_keys = '0;
      priority if (s2 > cfg.ladder_two_edge && s2 <= cfg.no_button_level) begin
         two_keys[0] = 1'b1;
      end else if (s2 <= cfg.ladder_two_edge) begin
         two_keys[1] = 1'b1;
      end else begin
         two_keys = '0;
      end
   end

   // power key is active low
   assign raw_keys = {~sample.power_pin_high, two_keys, one_keys};

endmodule

`default_nettype wire

@@ hw/rtl/ldbd_debounce.sv @@
// ladder button debouncer settle timer, stable mask and press timing state
// depends on ldbd_pkg for key_mask_type, result_type and widths
`default_nettype none

module ldbd_debounce
   import ldbd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire key_mask_type          raw_keys,
   input  wire logic [TIME_BITS-1:0]  now_ms,
   input  wire logic [DELAY_BITS-1:0] settle_delay_ms,
   output result_type                 result
);

   key_mask_type          raw_previous_ff, raw_previous_in;
   key_mask_type          stable_mask_ff, stable_mask_in;
   logic [TIME_BITS-1:0]  change_time_ff, change_time_in;
   logic [TIME_BITS-1:0]  start_time_ff, start_time_in;
   logic [TIME_BITS-1:0]  finish_time_ff, finish_time_in;

   logic                  changed;
   logic [TIME_BITS-1:0]  elapsed;
   logic                  settle;
   key_mask_type          pressed;
   key_mask_type          released;

   // a raw change restarts the timer from that beat's time and holds off settling on that beat
   assign changed         = raw_keys != raw_previous_ff;
   assign raw_previous_in = raw_keys;
   assign change_time_in  = changed ? now_ms : change_time_ff;
   assign elapsed         = now_ms - change_time_ff;
   assign settle          = !changed
                            && (elapsed > {{(TIME_BITS-DELAY_BITS){1'b0}}, settle_delay_ms})
                            && (raw_keys != stable_mask_ff);

   // edges against the stable mask
   assign pressed  = settle ? (raw_keys & ~stable_mask_ff) : '0;
   assign released = settle ? (stable_mask_ff & ~raw_keys) : '0;

   assign stable_mask_in = settle ? raw_keys : stable_mask_ff;
   assign start_time_in  = ((pressed != '0) && (stable_mask_ff == '0)) ? now_ms
                                                                        : start_time_ff;
   assign finish_time_in = ((released != '0) && (raw_keys == '0)) ? now_ms
                                                                   : finish_time_ff;

   // result for this beat
   always_comb begin
      result.stable_keys   = stable_mask_in;
      result.pressed_keys  = pressed;
      result.released_keys = released;
      if (stable_mask_in != '0) begin
         result.held_ms = now_ms - start_time_in;
      end else begin
         result.held_ms = finish_time_in - start_time_in;
      end
   end

   // state moves only when a beat passes to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_previous_ff <= '0;
         stable_mask_ff  <= '0;
         change_time_ff  <= '0;
         start_time_ff   <= '0;
         finish_time_ff  <= '0;
      end else if (advance) begin
         raw_previous_ff <= raw_previous_in;
         stable_mask_ff  <= stable_mask_in;
         change_time_ff  <= change_time_in;
         start_time_ff   <= start_time_in;
         finish_time_ff  <= finish_time_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/ladder_button_debouncer_unit.sv @@
// Ladder button debouncer. Each req beat is one sample tick with two 12-bit ladder
// ADC readings, the active-low power pin and the millisecond time; each produces
// exactly one rsp beat with the debounced key mask, the keys pressed and released
// at that tick and the held time. A beat passes through an input register, one
// level of decode, timer compare and subtract logic, and a result register; a new
// beat is taken every cycle while the result drains; while a finished result waits
// on rsp_tready the input register takes one more beat, then holds off req_tready. The
// user must write settings through the csr port while the stream is idle; the block does not enforce it.
// Depends on ldbd_pkg, ldbd_csr, ldbd_key_decode and ldbd_debounce.
`default_nettype none

module ladder_button_debouncer_unit
   import ldbd_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   // fields from bit 0: ladder_one_sample[12], ladder_two_sample[12],
   // power_pin_high[1], now_ms[32], zero pad
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [REQ_DATA_BITS-1:0]  req_tdata,
   // fields from bit 0: stable_keys[7], pressed_keys[7], released_keys[7],
   // held_ms[32], zero pad
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]       rsp_tdata,
   input  wire logic                      csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type      cfg;
   sample_type   sample_ff, sample_in;
   logic         in_valid_ff, in_valid_in;
   result_type   result;
   result_type   out_ff, out_in;
   logic         out_valid_ff, out_valid_in;
   logic         advance;
   key_mask_type raw_keys;

   ldbd_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   // beat moves to the result register when that register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // input register
   assign sample_in   = (req_tvalid && req_tready) ? sample_type'(req_tdata[REQ_FIELD_BITS-1:0])
                                                   : sample_ff;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   ldbd_key_decode u_key_decode (
      .cfg      (cfg),
      .sample   (sample_ff),
      .raw_keys (raw_keys)
   );

   ldbd_debounce u_debounce (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .raw_keys        (raw_keys),
      .now_ms          (sample_ff.now_ms),
      .settle_delay_ms (cfg.settle_delay_ms),
      .result          (result)
   );

   // result register
   assign out_in       = advance ? result : out_ff;
   assign out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      out_ff    <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS-RSP_FIELD_BITS){1'b0}}, out_ff};

endmodule

`default_nettype wire
